@@ design/kcl_pkg.sv @@
// Shared types, constants and helper functions for the keypad combination lock.
// Used by the channel interfaces, kcl_step and keypad_combination_lock_core.
package kcl_pkg;

    localparam int CODE_LENGTH = 5;
    localparam int POS_W       = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W       = $clog2(CODE_LENGTH);
    localparam int KEYS        = 16;
    localparam int KEY_W       = 5;
    localparam int CODE_W      = 4;

    localparam logic [KEY_W-1:0] NO_KEY   = 5'd0;
    localparam logic [KEY_W-1:0] STAR_KEY = 5'd4;

    typedef enum logic [2:0] {
        LK_START = 3'd0,
        LK_INIT  = 3'd1,
        LK_WAIT  = 3'd2,
        LK_CHECK = 3'd3,
        LK_RESET = 3'd4,
        LK_OPEN  = 3'd5
    } t_lock_phase;

    typedef enum logic [1:0] {
        BT_START = 2'd0,
        BT_IDLE  = 2'd1,
        BT_HELD  = 2'd2
    } t_button_phase;

    typedef enum logic [2:0] {
        ED_START        = 3'd0,
        ED_WAIT_COMBO   = 3'd1,
        ED_WAIT_RELEASE = 3'd2,
        ED_INPUT        = 3'd3,
        ED_KEY_HELD     = 3'd4
    } t_edit_phase;

    typedef struct packed {
        logic             unlocked;
        logic [KEY_W-1:0] pressed_key;
        logic             editing;
    } t_result;

    // Reset contents of the code store: the keys # 1 2 3 4, stored as key minus one.
    function automatic logic [CODE_W-1:0] code_reset(input int idx);
        logic [CODE_W-1:0] v;
        unique case (idx)
            0:       v = 4'd11;
            1:       v = 4'd0;
            2:       v = 4'd4;
            3:       v = 4'd8;
            4:       v = 4'd1;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // The lowest set bit wins; the result is its index plus one, or zero.
    function automatic logic [KEY_W-1:0] decode_key(input logic [KEYS-1:0] m);
        logic [KEY_W-1:0] k;
        k = NO_KEY;
        for (int b = KEYS - 1; b >= 0; b--) begin
            if (m[b]) begin
                k = KEY_W'(b + 1);
            end
        end
        return k;
    endfunction

endpackage

@@ design/kcl_ifs.sv @@
// Valid/ready channel interfaces for the keypad lock's sample input and result output.
// Depends on kcl_pkg for the field widths.
interface kcl_in_if;
    logic                          valid;
    logic                          ready;
    logic [kcl_pkg::KEYS-1:0]      key_matrix;
    logic                          lock_button;

    modport source (output valid, output key_matrix, output lock_button, input ready);
    modport sink   (input valid, input key_matrix, input lock_button, output ready);
endinterface

interface kcl_out_if;
    logic                          valid;
    logic                          ready;
    logic                          unlocked;
    logic [kcl_pkg::KEY_W-1:0]     pressed_key;
    logic                          editing;

    modport source (output valid, output unlocked, output pressed_key, output editing,
                    input ready);
    modport sink   (input valid, input unlocked, input pressed_key, input editing,
                    output ready);
endinterface

@@ design/kcl_step.sv @@
// Lock, button and edit state machines plus the code store, advanced once per sample.
// Depends on kcl_pkg.
module kcl_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [kcl_pkg::KEY_W-1:0] i_key,
    input  logic                      i_held,
    output kcl_pkg::t_result          o_result
);

    kcl_pkg::t_lock_phase   r_lock,   n_lock;
    kcl_pkg::t_button_phase r_button, n_button;
    kcl_pkg::t_edit_phase   r_edit,   n_edit;

    logic [kcl_pkg::POS_W-1:0]  r_match_pos, n_match_pos;
    logic [kcl_pkg::POS_W-1:0]  r_edit_pos,  n_edit_pos;
    logic                       r_open,      n_open;
    logic [kcl_pkg::CODE_W-1:0] r_code [kcl_pkg::CODE_LENGTH];

    logic [kcl_pkg::POS_W-1:0]  pos;
    logic [kcl_pkg::KEY_W-1:0]  stored_key;
    logic                       key_down;
    logic                       code_we;
    logic [kcl_pkg::IDX_W-1:0]  code_idx;

    assign key_down = (i_key != kcl_pkg::NO_KEY);

    always_comb begin
        pos = (r_match_pos >= kcl_pkg::POS_W'(kcl_pkg::CODE_LENGTH)) ? '0 : r_match_pos;
        stored_key = {1'b0, r_code[pos[kcl_pkg::IDX_W-1:0]]} + kcl_pkg::KEY_W'(1);
    end

    // Lock machine first; the button machine may then override the open flag.
    always_comb begin
        n_lock      = r_lock;
        n_match_pos = r_match_pos;
        unique case (r_lock)
            kcl_pkg::LK_START: n_lock = kcl_pkg::LK_INIT;
            kcl_pkg::LK_INIT:  n_lock = kcl_pkg::LK_WAIT;
            kcl_pkg::LK_WAIT: begin
                if (key_down) begin
                    n_lock = (i_key == stored_key) ? kcl_pkg::LK_CHECK : kcl_pkg::LK_RESET;
                end
            end
            kcl_pkg::LK_CHECK: begin
                if (pos == kcl_pkg::POS_W'(kcl_pkg::CODE_LENGTH - 1)) begin
                    n_lock = kcl_pkg::LK_OPEN;
                end else if (!key_down) begin
                    n_lock      = kcl_pkg::LK_WAIT;
                    n_match_pos = pos + kcl_pkg::POS_W'(1);
                end
            end
            kcl_pkg::LK_RESET, kcl_pkg::LK_OPEN: begin
                if (!key_down) begin
                    n_lock = kcl_pkg::LK_WAIT;
                end
                n_match_pos = '0;
            end
            default: n_lock = kcl_pkg::LK_START;
        endcase

        n_button = r_button;
        unique case (r_button)
            kcl_pkg::BT_START: n_button = kcl_pkg::BT_IDLE;
            kcl_pkg::BT_IDLE:  if (i_held)  n_button = kcl_pkg::BT_HELD;
            kcl_pkg::BT_HELD:  if (!i_held) n_button = kcl_pkg::BT_IDLE;
            default:           n_button = kcl_pkg::BT_START;
        endcase

        priority if (n_button == kcl_pkg::BT_HELD) begin
            n_open = 1'b0;
        end else if (n_lock == kcl_pkg::LK_INIT) begin
            n_open = 1'b0;
        end else if (n_lock == kcl_pkg::LK_OPEN) begin
            n_open = 1'b1;
        end else begin
            n_open = r_open;
        end
    end

    // Edit machine: the next keys after the combo overwrite entries one onward.
    always_comb begin
        n_edit     = r_edit;
        n_edit_pos = r_edit_pos;
        unique case (r_edit)
            kcl_pkg::ED_START: n_edit = kcl_pkg::ED_WAIT_COMBO;
            kcl_pkg::ED_WAIT_COMBO: begin
                if (i_held && i_key == kcl_pkg::STAR_KEY) begin
                    n_edit = kcl_pkg::ED_WAIT_RELEASE;
                end
            end
            kcl_pkg::ED_WAIT_RELEASE: begin
                if (!i_held && i_key != kcl_pkg::STAR_KEY) begin
                    n_edit = kcl_pkg::ED_INPUT;
                end
            end
            kcl_pkg::ED_INPUT: begin
                if (r_edit_pos >= kcl_pkg::POS_W'(kcl_pkg::CODE_LENGTH)) begin
                    n_edit_pos = kcl_pkg::POS_W'(1);
                    n_edit     = kcl_pkg::ED_WAIT_COMBO;
                end else if (key_down) begin
                    n_edit = kcl_pkg::ED_KEY_HELD;
                end
            end
            kcl_pkg::ED_KEY_HELD: begin
                if (!key_down) begin
                    n_edit_pos = r_edit_pos + kcl_pkg::POS_W'(1);
                    n_edit     = kcl_pkg::ED_INPUT;
                end
            end
            default: n_edit = kcl_pkg::ED_START;
        endcase

        code_we  = (n_edit == kcl_pkg::ED_KEY_HELD) && key_down &&
                   (n_edit_pos < kcl_pkg::POS_W'(kcl_pkg::CODE_LENGTH));
        code_idx = n_edit_pos[kcl_pkg::IDX_W-1:0];
    end

    always_comb begin
        o_result.unlocked    = n_open;
        o_result.pressed_key = i_key;
        o_result.editing     = (n_edit == kcl_pkg::ED_INPUT) ||
                               (n_edit == kcl_pkg::ED_KEY_HELD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock      <= kcl_pkg::LK_START;
            r_button    <= kcl_pkg::BT_START;
            r_edit      <= kcl_pkg::ED_START;
            r_match_pos <= '0;
            r_edit_pos  <= kcl_pkg::POS_W'(1);
            r_open      <= 1'b0;
            for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
                r_code[i] <= kcl_pkg::code_reset(i);
            end
        end else if (i_en) begin
            r_lock      <= n_lock;
            r_button    <= n_button;
            r_edit      <= n_edit;
            r_match_pos <= n_match_pos;
            r_edit_pos  <= n_edit_pos;
            r_open      <= n_open;
            if (code_we) begin
                r_code[code_idx] <= kcl_pkg::CODE_W'(i_key - kcl_pkg::KEY_W'(1));
            end
        end
    end

endmodule

@@ design/keypad_combination_lock_core.sv @@
// Keypad combination lock: registered sample in, one step of the lock logic, registered result out.
// A sample waits in the input register until the result register is empty or being emptied; its
// result is then registered and presented. Throughput: one sample per cycle while the result side
// stays ready; the step logic is a single pass between the two registers.
// Reset (synchronous, active low) empties both registers and returns all machines to start.
// Depends on kcl_pkg, kcl_ifs and kcl_step.
module keypad_combination_lock_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kcl_in_if.sink   i_in,
    kcl_out_if.source o_out
);

    logic                        r_in_valid;
    logic [kcl_pkg::KEYS-1:0]    r_key_matrix;
    logic                        r_lock_button;
    logic                        r_out_valid;
    kcl_pkg::t_result            r_result;

    logic                        advance;
    logic [kcl_pkg::KEY_W-1:0]   key;
    kcl_pkg::t_result            n_result;

    // A stored sample moves on whenever the result register is empty or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign key        = kcl_pkg::decode_key(r_key_matrix);

    kcl_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_key    (key),
        .i_held   (r_lock_button),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_key_matrix  <= i_in.key_matrix;
            r_lock_button <= i_in.lock_button;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.unlocked    = r_result.unlocked;
    assign o_out.pressed_key = r_result.pressed_key;
    assign o_out.editing     = r_result.editing;

endmodule

@@ bench/keypad_combination_lock_core_tb.sv @@
// Self-checking testbench for keypad_combination_lock_core: directed script, then random code entry,
// code edit and noise sequences, checked against a per-sample predictor or the script's expected results.
// Depends on kcl_pkg, kcl_ifs and the core's design files.
module keypad_combination_lock_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    localparam int NUM_SAMPLES  = 900;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int SCRIPT_ROWS  = 28;

    typedef struct {
        logic [KEYS-1:0] keys;
        logic            btn;
        bit              has_want;
        t_result         want;
    } t_keypad_row;

    logic i_clk;
    logic i_rst_n;

    kcl_in_if  in_if ();
    kcl_out_if out_if ();

    keypad_combination_lock_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted state of the three machines and the stored code.
    t_lock_phase      lk_phase;
    logic [2:0]       lk_match;
    logic             lk_open;
    t_button_phase    bt_phase;
    t_edit_phase      ed_phase;
    logic [2:0]       ed_pos;
    logic [CODE_W-1:0] code_keys [CODE_LENGTH];

    t_result pending_results [$];
    int      error_count   = 0;
    int      samples_sent  = 0;
    bit      steady        = 1'b0;
    bit      hold_req      = 1'b0;

    // Walk the keypad through code "# 1 2 3 4", open, lock with the button held,
    // then enter edit mode and overwrite entries 1 to 4.
    t_keypad_row keypad_script [SCRIPT_ROWS] = '{
        '{16'h0000, 1'b0, 1'b1, {1'b0, 5'd0,  1'b0}},
        '{16'hFFFF, 1'b0, 1'b1, {1'b0, 5'd1,  1'b0}},
        '{16'h8000, 1'b0, 1'b1, {1'b0, 5'd16, 1'b0}},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0800, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h8001, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0010, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0100, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0002, 1'b0, 1'b0, '0},
        '{16'h0002, 1'b0, 1'b1, {1'b1, 5'd2,  1'b0}},
        '{16'h0002, 1'b1, 1'b1, {1'b0, 5'd2,  1'b0}},
        '{16'h0008, 1'b1, 1'b0, '0},
        '{16'h0008, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h1000, 1'b0, 1'b0, '0},
        '{16'h4000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0020, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0200, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0}
    };

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One tick of the lock: lock machine, then button machine, then edit machine.
    function automatic t_result advance_lock(input logic [KEYS-1:0] m, input logic held);
        logic [KEY_W-1:0] key;
        logic [2:0]       pos;
        t_result          r;
        key = NO_KEY;
        for (int b = 0; b < KEYS; b++) begin
            if (key == NO_KEY && m[b]) begin
                key = KEY_W'(b + 1);
            end
        end
        pos = (lk_match >= 3'(CODE_LENGTH)) ? 3'd0 : lk_match;

        case (lk_phase)
            LK_START: lk_phase = LK_INIT;
            LK_INIT:  lk_phase = LK_WAIT;
            LK_WAIT: begin
                if (key != NO_KEY) begin
                    lk_phase = (key == KEY_W'(code_keys[pos]) + 5'd1) ? LK_CHECK : LK_RESET;
                end
            end
            LK_CHECK: begin
                if (pos == 3'(CODE_LENGTH - 1)) begin
                    lk_phase = LK_OPEN;
                end else if (key == NO_KEY) begin
                    lk_phase = LK_WAIT;
                    lk_match = 3'(pos + 1);
                end
            end
            LK_RESET, LK_OPEN: begin
                if (key == NO_KEY) begin
                    lk_phase = LK_WAIT;
                end
                lk_match = 3'd0;
            end
            default: lk_phase = LK_START;
        endcase
        if (lk_phase == LK_INIT) begin
            lk_open = 1'b0;
        end else if (lk_phase == LK_OPEN) begin
            lk_open = 1'b1;
        end

        case (bt_phase)
            BT_START: bt_phase = BT_IDLE;
            BT_IDLE:  if (held) bt_phase = BT_HELD;
            BT_HELD:  if (!held) bt_phase = BT_IDLE;
            default:  bt_phase = BT_START;
        endcase
        // A held button keeps the lock shut, even on the tick that would open it.
        if (bt_phase == BT_HELD) begin
            lk_open = 1'b0;
        end

        case (ed_phase)
            ED_START: ed_phase = ED_WAIT_COMBO;
            ED_WAIT_COMBO: begin
                if (held && key == STAR_KEY) begin
                    ed_phase = ED_WAIT_RELEASE;
                end
            end
            ED_WAIT_RELEASE: begin
                if (!held && key != STAR_KEY) begin
                    ed_phase = ED_INPUT;
                end
            end
            ED_INPUT: begin
                if (ed_pos >= 3'(CODE_LENGTH)) begin
                    ed_pos   = 3'd1;
                    ed_phase = ED_WAIT_COMBO;
                end else if (key != NO_KEY) begin
                    ed_phase = ED_KEY_HELD;
                end
            end
            ED_KEY_HELD: begin
                if (key == NO_KEY) begin
                    ed_pos   = 3'(ed_pos + 1);
                    ed_phase = ED_INPUT;
                end
            end
            default: ed_phase = ED_START;
        endcase
        // A key that changes while held overwrites the same entry.
        if (ed_phase == ED_KEY_HELD && key != NO_KEY && ed_pos < 3'(CODE_LENGTH)) begin
            code_keys[ed_pos] = CODE_W'(key - 5'd1);
        end

        r.unlocked    = lk_open;
        r.pressed_key = key;
        r.editing     = (ed_phase == ED_INPUT || ed_phase == ED_KEY_HELD);
        return r;
    endfunction

    // Matrix with key k down, plus random keys later in scan order when noisy.
    function automatic logic [KEYS-1:0] key_bits(input int k, input bit noisy);
        logic [KEYS-1:0] one;
        one = KEYS'(1) << (k - 1);
        return noisy ? (one | (KEYS'($urandom) & ~((one << 1) - KEYS'(1)))) : one;
    endfunction

    task automatic send_sample(input logic [KEYS-1:0] m, input logic b,
                               input bit has_want = 1'b0, input t_result want = '0);
        t_result predicted;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 16) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.key_matrix  <= m;
        in_if.lock_button <= b;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        predicted = advance_lock(m, b);
        pending_results.push_back(has_want ? want : predicted);
        samples_sent++;
    endtask

    task automatic tap_key(input int k, input logic b);
        repeat ($urandom_range(1, 3)) send_sample(key_bits(k, $urandom_range(3) == 0), b);
        repeat ($urandom_range(1, 2)) send_sample('0, b);
    endtask

    task automatic enter_code();
        int   k;
        logic b;
        b = ($urandom_range(9) == 0);
        for (int i = 0; i < CODE_LENGTH; i++) begin
            k = int'(code_keys[i]) + 1;
            if ($urandom_range(9) == 0) begin
                k = $urandom_range(1, KEYS);
            end
            tap_key(k, b);
        end
        if ($urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 2)) send_sample('0, 1'b1);
            send_sample('0, 1'b0);
        end
    endtask

    task automatic edit_code();
        int k;
        send_sample('0, 1'b1);
        repeat ($urandom_range(1, 2)) send_sample(key_bits(STAR_KEY, 1'b0), 1'b1);
        if ($urandom_range(1) == 1) begin
            send_sample(key_bits(STAR_KEY, 1'b0), 1'b0);
        end
        send_sample('0, 1'b0);
        for (int i = 1; i < CODE_LENGTH; i++) begin
            k = $urandom_range(1, KEYS);
            repeat ($urandom_range(1, 2)) send_sample(key_bits(k, $urandom_range(3) == 0), 1'b0);
            if ($urandom_range(4) == 0) begin
                send_sample(key_bits($urandom_range(1, KEYS), 1'b0), 1'b0);
            end
            send_sample('0, 1'b0);
        end
        send_sample('0, 1'b0);
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.key_matrix  = '0;
        in_if.lock_button = 1'b0;
        out_if.ready      = 1'b0;
        lk_phase          = LK_START;
        lk_match          = 3'd0;
        lk_open           = 1'b0;
        bt_phase          = BT_START;
        ed_phase          = ED_START;
        ed_pos            = 3'd1;
        code_keys         = '{4'd11, 4'd0, 4'd4, 4'd8, 4'd1};
    end

    // Result side: random back-pressure outside the steady episodes, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_if.ready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation: unlocked=%0d pressed_key=%0d editing=%0d",
                       out_if.unlocked, out_if.pressed_key, out_if.editing);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.unlocked !== want.unlocked) begin
                    $error("unlocked: expected %0d, got %0d", want.unlocked, out_if.unlocked);
                    error_count++;
                end
                if (out_if.pressed_key !== want.pressed_key) begin
                    $error("pressed_key: expected %0d, got %0d",
                           want.pressed_key, out_if.pressed_key);
                    error_count++;
                end
                if (out_if.editing !== want.editing) begin
                    $error("editing: expected %0d, got %0d", want.editing, out_if.editing);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int episode;
        int pick;
        episode = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            send_sample(keypad_script[r].keys, keypad_script[r].btn,
                        keypad_script[r].has_want, keypad_script[r].want);
        end

        while (samples_sent < NUM_SAMPLES) begin
            episode++;
            if (episode == 8) begin
                hold_req = 1'b1;
            end
            if (episode == 30) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
                wait_for_results();
            end
            steady = (episode >= 60 && episode < 110);
            pick = $urandom_range(99);
            if (pick < 45) begin
                enter_code();
            end else if (pick < 65) begin
                edit_code();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_sample(($urandom_range(3) == 0) ? '0 : KEYS'($urandom),
                                1'($urandom_range(1)));
                end
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/kcl_pkg.sv
design/kcl_ifs.sv
design/kcl_step.sv
design/keypad_combination_lock_core.sv
bench/keypad_combination_lock_core_tb.sv
